### src/gdbf_pkg.sv
// Shared constants, types and lookup tables of the guided depth bilateral filter.
// Used by every module in src except gdbf_ram; depends on nothing else.
package gdbf_pkg;

    localparam int GRID_ROWS   = 64;
    localparam int GRID_WIDTH  = 1024;
    localparam int MAX_WINDOW  = 9;

    localparam int FWD         = (MAX_WINDOW - 1) / 2;
    localparam int DELAY       = FWD * GRID_WIDTH + FWD;
    localparam int TOTAL       = GRID_ROWS * GRID_WIDTH;
    localparam int STORE_CELLS = MAX_WINDOW * GRID_WIDTH;

    localparam int DEPTH_W     = 20;
    localparam int CHAN_W      = 8;
    localparam int CELL_W      = 45;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 40;
    localparam int OUT_ROW_W   = 6;
    localparam int OUT_COL_W   = 10;

    localparam int ROW_W       = $clog2(GRID_ROWS);
    localparam int COL_W       = $clog2(GRID_WIDTH);
    localparam int RMOD_W      = $clog2(MAX_WINDOW);
    localparam int ADDR_W      = $clog2(STORE_CELLS);
    localparam int POS_W       = $clog2(TOTAL + DELAY + 1);
    localparam int IDX_W       = $clog2(TOTAL);
    localparam int OFF_W       = $clog2(MAX_WINDOW) + 1;
    localparam int HALF_W      = $clog2((MAX_WINDOW / 2) * (MAX_WINDOW / 2) + 1);

    localparam int WS_W        = 4;
    localparam int INV_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int WS_RESET    = 7;
    localparam int SP_RESET    = 25600;
    localparam int RG_RESET    = 91;

    localparam int S_W         = 18;
    localparam int V_W         = 26;
    localparam int ROOT_W      = 13;
    localparam int RNG_W       = ROOT_W + INV_W;
    localparam int SP_W        = HALF_W + INV_W;
    localparam int X_W         = ((SP_W > RNG_W - 8) ? SP_W : RNG_W - 8) + 1;
    localparam int EXP_STEPS   = 12;
    localparam int W_W         = 17;
    localparam int PROD_W      = 38;
    localparam int CNT_W       = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int NUM_W       = PROD_W + CNT_W;
    localparam int DEN_W       = W_W + CNT_W;
    localparam int DIVCNT_W    = $clog2(NUM_W + 1);

    localparam int DEPTH_POS_MAX = 524287;
    localparam int DEPTH_NEG_MAG = 524288;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE = 2'd0,
        CFG_SPATIAL_INV = 2'd1,
        CFG_RANGE_INV   = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER_RD,
        S_CENTER_LAT,
        S_ISSUE,
        S_FLUSH,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic rd_center;
        logic latch_center;
        logic win_start;
        logic issue;
        logic div_start;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit;
        logic center_valid;
        logic last_issue;
        logic pipe_empty;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // round(65536 * exp(-n))
    function automatic logic [W_W-1:0] exp_int(input logic [3:0] n);
        logic [W_W-1:0] v;
        begin
            case (n)
                4'd0:    v = 17'd65536;
                4'd1:    v = 17'd24109;
                4'd2:    v = 17'd8869;
                4'd3:    v = 17'd3263;
                4'd4:    v = 17'd1200;
                4'd5:    v = 17'd442;
                4'd6:    v = 17'd162;
                4'd7:    v = 17'd60;
                4'd8:    v = 17'd22;
                4'd9:    v = 17'd8;
                4'd10:   v = 17'd3;
                4'd11:   v = 17'd1;
                default: v = 17'd0;
            endcase
            return v;
        end
    endfunction

    // round(65536 * exp(-k/32))
    function automatic logic [W_W-1:0] exp_frac(input logic [4:0] k);
        logic [W_W-1:0] v;
        begin
            case (k)
                5'd0:    v = 17'd65536;
                5'd1:    v = 17'd63520;
                5'd2:    v = 17'd61565;
                5'd3:    v = 17'd59671;
                5'd4:    v = 17'd57835;
                5'd5:    v = 17'd56056;
                5'd6:    v = 17'd54331;
                5'd7:    v = 17'd52660;
                5'd8:    v = 17'd51039;
                5'd9:    v = 17'd49469;
                5'd10:   v = 17'd47947;
                5'd11:   v = 17'd46472;
                5'd12:   v = 17'd45042;
                5'd13:   v = 17'd43657;
                5'd14:   v = 17'd42314;
                5'd15:   v = 17'd41012;
                5'd16:   v = 17'd39750;
                5'd17:   v = 17'd38527;
                5'd18:   v = 17'd37341;
                5'd19:   v = 17'd36192;
                5'd20:   v = 17'd35079;
                5'd21:   v = 17'd34000;
                5'd22:   v = 17'd32954;
                5'd23:   v = 17'd31940;
                5'd24:   v = 17'd30957;
                5'd25:   v = 17'd30005;
                5'd26:   v = 17'd29081;
                5'd27:   v = 17'd28187;
                5'd28:   v = 17'd27319;
                5'd29:   v = 17'd26479;
                5'd30:   v = 17'd25664;
                default: v = 17'd24875;
            endcase
            return v;
        end
    endfunction

endpackage

### src/gdbf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gdbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/gdbf_div.sv
// Restoring divider, one quotient bit per cycle, for the weighted mean.
// Depends on gdbf_pkg for the operand widths.
module gdbf_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gdbf_pkg::NUM_W-1:0] dividend,
    input  logic [gdbf_pkg::DEN_W-1:0] divisor,
    output logic                       busy,
    output logic [gdbf_pkg::NUM_W-1:0] quotient
);

    import gdbf_pkg::*;

    logic                busy_reg;
    logic [DIVCNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]    dvd_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DEN_W-1:0]    dsr_reg;
    logic [DEN_W:0]      rem_sh;
    logic                ge;
    logic [DEN_W:0]      rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[NUM_W-1]};
        ge      = rem_sh >= {1'b0, dsr_reg};
        rem_sub = rem_sh - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIVCNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIVCNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule

### src/gdbf_ctrl.sv
// Sequencer of the filter: accepts words, walks the window, runs the divide.
// Depends on gdbf_pkg for the state, command and status types.
module gdbf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  gdbf_pkg::dp_status_t   status,
    output gdbf_pkg::ctrl_cmd_t    cmd
);

    import gdbf_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && status.emit)
                begin
                    state_next = S_CENTER_RD;
                end
            end
            S_CENTER_RD:  state_next = S_CENTER_LAT;
            S_CENTER_LAT: state_next = status.center_valid ? S_ISSUE : S_RESULT;
            S_ISSUE:
            begin
                if (status.last_issue)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (status.pipe_empty)
                begin
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:     state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            S_CENTER_RD:  cmd.rd_center = 1'b1;
            S_CENTER_LAT:
            begin
                cmd.latch_center = 1'b1;
                cmd.win_start    = 1'b1;
            end
            S_ISSUE:      cmd.issue = 1'b1;
            S_FLUSH:      ;
            S_DIV_GO:     cmd.div_start = 1'b1;
            S_DIV_WAIT:   ;
            S_RESULT:     cmd.load_result = status.out_free;
            default:      ;
        endcase
    end

endmodule

### src/gdbf_dp.sv
// Datapath: grid counters, line store, weight pipeline, accumulators, result register.
// Depends on gdbf_pkg, gdbf_ram and gdbf_div.
module gdbf_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [gdbf_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           cfg_wr_en,
    input  logic [gdbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gdbf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  gdbf_pkg::ctrl_cmd_t            cmd,
    output gdbf_pkg::dp_status_t           status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gdbf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);

    import gdbf_pkg::*;

    // configuration
    logic [WS_W-1:0]  win_size_reg;
    logic [INV_W-1:0] spatial_inv_reg;
    logic [INV_W-1:0] range_inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg    <= WS_W'(WS_RESET);
            spatial_inv_reg <= INV_W'(SP_RESET);
            range_inv_reg   <= INV_W'(RG_RESET);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WINDOW_SIZE: win_size_reg    <= cfg_data[WS_W-1:0];
                CFG_SPATIAL_INV: spatial_inv_reg <= cfg_data[INV_W-1:0];
                CFG_RANGE_INV:   range_inv_reg   <= cfg_data[INV_W-1:0];
                default:         ;
            endcase
        end
    end

    // grid counters
    logic [POS_W-1:0]  in_pos_reg;
    logic [COL_W-1:0]  in_col_reg;
    logic [RMOD_W-1:0] in_rmod_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [RMOD_W-1:0] out_rmod_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [RMOD_W-1:0] cur_rmod_reg;
    logic              cur_last_reg;

    logic              in_frame;
    logic              drain;
    logic              ignore;
    logic [POS_W-1:0]  pos_inc;
    logic              emit;
    logic              frame_end;

    always_comb
    begin
        in_frame  = in_pos_reg < POS_W'(TOTAL);
        drain     = s_tuser;
        ignore    = in_frame && drain;
        pos_inc   = in_pos_reg + 1'b1;
        emit      = !ignore && (pos_inc > POS_W'(out_idx_reg) + POS_W'(DELAY));
        frame_end = out_idx_reg == IDX_W'(TOTAL - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pos_reg   <= '0;
            in_col_reg   <= '0;
            in_rmod_reg  <= '0;
            out_idx_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_rmod_reg <= '0;
        end
        else if (cmd.accept && !ignore)
        begin
            if (emit && frame_end)
            begin
                in_pos_reg   <= '0;
                in_col_reg   <= '0;
                in_rmod_reg  <= '0;
                out_idx_reg  <= '0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                out_rmod_reg <= '0;
            end
            else
            begin
                in_pos_reg <= pos_inc;
                if (in_col_reg == COL_W'(GRID_WIDTH - 1))
                begin
                    in_col_reg  <= '0;
                    in_rmod_reg <= (in_rmod_reg == RMOD_W'(MAX_WINDOW - 1)) ?
                                   '0 : in_rmod_reg + 1'b1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
                if (emit)
                begin
                    out_idx_reg <= out_idx_reg + 1'b1;
                    if (out_col_reg == COL_W'(GRID_WIDTH - 1))
                    begin
                        out_col_reg  <= '0;
                        out_row_reg  <= out_row_reg + 1'b1;
                        out_rmod_reg <= (out_rmod_reg == RMOD_W'(MAX_WINDOW - 1)) ?
                                        '0 : out_rmod_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && emit)
        begin
            cur_row_reg  <= out_row_reg;
            cur_col_reg  <= out_col_reg;
            cur_rmod_reg <= out_rmod_reg;
            cur_last_reg <= frame_end;
        end
    end

    // window walk
    logic [WS_W-1:0]         win_r;
    logic [WS_W-1:0]         half_r;
    logic signed [OFF_W-1:0] lo_off;
    logic signed [OFF_W-1:0] hi_off;
    logic signed [OFF_W-1:0] nb_dy_reg;
    logic signed [OFF_W-1:0] nb_dx_reg;

    always_comb
    begin
        if (win_size_reg == '0)
        begin
            win_r = WS_W'(1);
        end
        else if (win_size_reg > WS_W'(MAX_WINDOW))
        begin
            win_r = WS_W'(MAX_WINDOW);
        end
        else
        begin
            win_r = win_size_reg;
        end
        half_r = win_r >> 1;
        lo_off = OFF_W'(0) - OFF_W'(half_r);
        hi_off = OFF_W'(win_r - WS_W'(1) - half_r);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.win_start)
        begin
            nb_dy_reg <= lo_off;
            nb_dx_reg <= lo_off;
        end
        else if (cmd.issue)
        begin
            if (nb_dx_reg == hi_off)
            begin
                nb_dx_reg <= lo_off;
                nb_dy_reg <= nb_dy_reg + 1'b1;
            end
            else
            begin
                nb_dx_reg <= nb_dx_reg + 1'b1;
            end
        end
    end

    logic signed [ROW_W+1:0]    ysum;
    logic signed [COL_W+1:0]    xsum;
    logic signed [RMOD_W+1:0]   tmod;
    logic [RMOD_W-1:0]          ymod;
    logic                       inb;
    logic [ADDR_W-1:0]          nb_addr;
    logic [ADDR_W-1:0]          center_addr;
    logic [ADDR_W-1:0]          waddr;
    logic [ADDR_W-1:0]          raddr;
    logic signed [2*OFF_W-1:0]  sq_dx;
    logic signed [2*OFF_W-1:0]  sq_dy;
    logic [2*OFF_W:0]           dist2;
    logic [HALF_W-1:0]          half_dist;

    always_comb
    begin
        ysum = $signed({2'b00, cur_row_reg}) + (ROW_W + 2)'(nb_dy_reg);
        xsum = $signed({2'b00, cur_col_reg}) + (COL_W + 2)'(nb_dx_reg);
        tmod = $signed({2'b00, cur_rmod_reg}) + (RMOD_W + 2)'(nb_dy_reg);
        if (tmod < 0)
        begin
            ymod = RMOD_W'(tmod + (RMOD_W + 2)'(MAX_WINDOW));
        end
        else if (tmod >= (RMOD_W + 2)'(MAX_WINDOW))
        begin
            ymod = RMOD_W'(tmod - (RMOD_W + 2)'(MAX_WINDOW));
        end
        else
        begin
            ymod = RMOD_W'(tmod);
        end
        inb = (ysum >= 0) && (ysum < (ROW_W + 2)'(GRID_ROWS))
           && (xsum >= 0) && (xsum < (COL_W + 2)'(GRID_WIDTH));
        nb_addr = inb ? ADDR_W'(ymod) * ADDR_W'(GRID_WIDTH) + ADDR_W'(xsum[COL_W-1:0])
                      : '0;
        center_addr = ADDR_W'(cur_rmod_reg) * ADDR_W'(GRID_WIDTH) + ADDR_W'(cur_col_reg);
        waddr = ADDR_W'(in_rmod_reg) * ADDR_W'(GRID_WIDTH) + ADDR_W'(in_col_reg);
        raddr = cmd.rd_center ? center_addr : nb_addr;
        sq_dx = nb_dx_reg * nb_dx_reg;
        sq_dy = nb_dy_reg * nb_dy_reg;
        dist2 = (2 * OFF_W + 1)'($unsigned(sq_dx)) + (2 * OFF_W + 1)'($unsigned(sq_dy));
        half_dist = HALF_W'(dist2 >> 1);
    end

    // line store
    logic [CELL_W-1:0] ram_rdata;

    gdbf_ram #(
        .WIDTH (CELL_W),
        .DEPTH (STORE_CELLS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.accept && in_frame && !drain),
        .waddr (waddr),
        .wdata (s_tdata[CELL_W-1:0]),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // centre cell
    logic signed [DEPTH_W-1:0] c0_depth_reg;
    logic [CHAN_W-1:0]         c0_red_reg;
    logic [CHAN_W-1:0]         c0_green_reg;
    logic [CHAN_W-1:0]         c0_blue_reg;
    logic                      c0_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_center)
        begin
            c0_depth_reg <= ram_rdata[DEPTH_W-1:0];
            c0_red_reg   <= ram_rdata[27:20];
            c0_green_reg <= ram_rdata[35:28];
            c0_blue_reg  <= ram_rdata[43:36];
            c0_valid_reg <= ram_rdata[44];
        end
    end

    // weight pipeline
    logic                      live_p0_reg;
    logic                      inb_p0_reg;
    logic [HALF_W-1:0]         half_p0_reg;

    logic                      live1_reg;
    logic                      vld1_reg;
    logic [S_W-1:0]            s1_reg;
    logic [SP_W-1:0]           sp1_reg;
    logic signed [DEPTH_W-1:0] dep1_reg;

    logic signed [CHAN_W:0]    dr;
    logic signed [CHAN_W:0]    dg;
    logic signed [CHAN_W:0]    db;
    logic signed [2*CHAN_W+1:0] sqr;
    logic signed [2*CHAN_W+1:0] sqg;
    logic signed [2*CHAN_W+1:0] sqb;
    logic [S_W:0]              s_sum;

    always_comb
    begin
        dr    = $signed({1'b0, c0_red_reg})   - $signed({1'b0, ram_rdata[27:20]});
        dg    = $signed({1'b0, c0_green_reg}) - $signed({1'b0, ram_rdata[35:28]});
        db    = $signed({1'b0, c0_blue_reg})  - $signed({1'b0, ram_rdata[43:36]});
        sqr   = dr * dr;
        sqg   = dg * dg;
        sqb   = db * db;
        s_sum = (S_W + 1)'($unsigned(sqr)) + (S_W + 1)'($unsigned(sqg))
              + (S_W + 1)'($unsigned(sqb));
    end

    logic [ROOT_W-1:0]         sq_live_reg;
    logic [ROOT_W-1:0]         sq_vld_reg;
    logic [V_W-1:0]            sq_v_reg    [ROOT_W];
    logic [ROOT_W-1:0]         sq_root_reg [ROOT_W];
    logic [SP_W-1:0]           sq_sp_reg   [ROOT_W];
    logic signed [DEPTH_W-1:0] sq_dep_reg  [ROOT_W];
    logic [V_W-1:0]            sq_vin      [ROOT_W];
    logic [ROOT_W-1:0]         sq_rin      [ROOT_W];
    logic [ROOT_W-1:0]         sq_cand     [ROOT_W];
    logic [V_W-1:0]            sq_square   [ROOT_W];
    logic [ROOT_W-1:0]         sq_root_next[ROOT_W];

    // one root bit per stage, most significant first
    always_comb
    begin
        for (int t = 0; t < ROOT_W; t++)
        begin
            if (t == 0)
            begin
                sq_vin[t] = {s1_reg, 8'h00};
                sq_rin[t] = '0;
            end
            else
            begin
                sq_vin[t] = sq_v_reg[t-1];
                sq_rin[t] = sq_root_reg[t-1];
            end
            sq_cand[t]      = sq_rin[t] | (ROOT_W'(1) << (ROOT_W - 1 - t));
            sq_square[t]    = sq_cand[t] * sq_cand[t];
            sq_root_next[t] = (sq_square[t] <= sq_vin[t]) ? sq_cand[t] : sq_rin[t];
        end
    end

    logic                      live2_reg;
    logic                      vld2_reg;
    logic [X_W-1:0]            x2_reg;
    logic signed [DEPTH_W-1:0] dep2_reg;
    logic [RNG_W-1:0]          rng_prod;

    logic                      live3_reg;
    logic [W_W-1:0]            w3_reg;
    logic signed [DEPTH_W-1:0] dep3_reg;
    logic [X_W-13:0]           xi;
    logic [33:0]               exp_prod;
    logic [33:0]               exp_round;
    logic [W_W-1:0]            w_calc;

    logic                      live4_reg;
    logic [W_W-1:0]            w4_reg;
    logic signed [PROD_W-1:0]  prod4_reg;

    logic signed [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]          den_reg;

    always_comb
    begin
        rng_prod  = sq_root_reg[ROOT_W-1] * range_inv_reg;
        xi        = x2_reg[X_W-1:12];
        exp_prod  = exp_int(xi[3:0]) * exp_frac(x2_reg[11:7]);
        exp_round = exp_prod + 34'd32768;
        if (!vld2_reg || xi >= (X_W - 12)'(EXP_STEPS))
        begin
            w_calc = '0;
        end
        else
        begin
            w_calc = exp_round[32:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_p0_reg <= 1'b0;
            live1_reg   <= 1'b0;
            sq_live_reg <= '0;
            live2_reg   <= 1'b0;
            live3_reg   <= 1'b0;
            live4_reg   <= 1'b0;
        end
        else
        begin
            live_p0_reg <= cmd.issue;
            live1_reg   <= live_p0_reg;
            sq_live_reg <= {sq_live_reg[ROOT_W-2:0], live1_reg};
            live2_reg   <= sq_live_reg[ROOT_W-1];
            live3_reg   <= live2_reg;
            live4_reg   <= live3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        inb_p0_reg  <= inb;
        half_p0_reg <= half_dist;

        vld1_reg <= live_p0_reg && inb_p0_reg && ram_rdata[44];
        s1_reg   <= s_sum[S_W-1:0];
        sp1_reg  <= half_p0_reg * spatial_inv_reg;
        dep1_reg <= ram_rdata[DEPTH_W-1:0];

        for (int t = 0; t < ROOT_W; t++)
        begin
            sq_v_reg[t]    <= sq_vin[t];
            sq_root_reg[t] <= sq_root_next[t];
            if (t == 0)
            begin
                sq_vld_reg[t] <= vld1_reg;
                sq_sp_reg[t]  <= sp1_reg;
                sq_dep_reg[t] <= dep1_reg;
            end
            else
            begin
                sq_vld_reg[t] <= sq_vld_reg[t-1];
                sq_sp_reg[t]  <= sq_sp_reg[t-1];
                sq_dep_reg[t] <= sq_dep_reg[t-1];
            end
        end

        vld2_reg <= sq_vld_reg[ROOT_W-1];
        x2_reg   <= X_W'(sq_sp_reg[ROOT_W-1]) + X_W'(rng_prod[RNG_W-1:8]);
        dep2_reg <= sq_dep_reg[ROOT_W-1];

        w3_reg   <= w_calc;
        dep3_reg <= dep2_reg;

        w4_reg    <= w3_reg;
        prod4_reg <= $signed({1'b0, w3_reg}) * dep3_reg;

        if (cmd.win_start)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (live4_reg)
        begin
            num_reg <= num_reg + NUM_W'(prod4_reg);
            den_reg <= den_reg + DEN_W'(w4_reg);
        end
    end

    // rounded divide, then saturate
    logic             num_neg;
    logic [NUM_W-1:0] num_mag;
    logic [NUM_W-1:0] dividend;
    logic             div_busy;
    logic [NUM_W-1:0] quotient;
    logic [DEPTH_W-1:0] sat_depth;

    always_comb
    begin
        num_neg  = num_reg[NUM_W-1];
        num_mag  = num_neg ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        dividend = num_mag + NUM_W'(den_reg >> 1);
        if (num_neg)
        begin
            sat_depth = (quotient > NUM_W'(DEPTH_NEG_MAG)) ? DEPTH_W'(DEPTH_NEG_MAG)
                                                            : DEPTH_W'(-quotient);
        end
        else
        begin
            sat_depth = (quotient > NUM_W'(DEPTH_POS_MAX)) ? DEPTH_W'(DEPTH_POS_MAX)
                                                            : quotient[DEPTH_W-1:0];
        end
    end

    gdbf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (den_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // result register
    logic                 out_valid_reg;
    logic [DEPTH_W-1:0]   res_depth_reg;
    logic [OUT_ROW_W-1:0] res_row_reg;
    logic [OUT_COL_W-1:0] res_col_reg;
    logic                 res_pass_reg;
    logic                 res_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            res_depth_reg <= c0_valid_reg ? sat_depth : c0_depth_reg;
            res_row_reg   <= OUT_ROW_W'(cur_row_reg);
            res_col_reg   <= OUT_COL_W'(cur_col_reg);
            res_pass_reg  <= !c0_valid_reg;
            res_last_reg  <= cur_last_reg;
        end
    end

    always_comb
    begin
        status.emit         = emit;
        status.center_valid = ram_rdata[44];
        status.last_issue   = (nb_dx_reg == hi_off) && (nb_dy_reg == hi_off);
        status.pipe_empty   = !(live_p0_reg || live1_reg || (|sq_live_reg)
                                || live2_reg || live3_reg || live4_reg);
        status.div_busy     = div_busy;
        status.out_free     = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - DEPTH_W - OUT_ROW_W - OUT_COL_W)'(0),
                       res_col_reg, res_row_reg, res_depth_reg};
    assign m_tuser  = res_pass_reg;
    assign m_tlast  = res_last_reg;

endmodule

### src/guided_depth_bilateral_filter.sv
// Guided depth bilateral filter: cells of a 64 by 1024 depth grid arrive in raster
// order; each cell with a guide colour leaves as the weighted mean of its window.
//
// Input stream (s_*): one word per grid cell; tuser high marks a drain tick.
// Drain ticks inside the frame are dropped; after the last cell they push
// the tail out, one result per tick. A result appears for the cell four rows
// and four cells behind the newest one, so the frame needs 4*1024+4 drain ticks.
// Output stream (m_*): one word per result cell, tlast on the final cell.
// Config port: cfg_wr_en, cfg_index (0 window size, 1 spatial_inv, 2 range_inv),
// cfg_data; write only while no word is in flight.
// Sequencing: a word that gives no result is taken straight from the idle state. A
// filtered cell has the shared weight pipeline take one neighbor per cycle from the
// line store read port, then waits for the pipeline flush and the bit-serial divide;
// pass-through cells skip both. No new word is taken until its result is loaded.
// Reset clears counters and config to defaults; the line store is not cleared.
// A stalled receiver holds the result register; the block keeps taking words
// until a new result has to be loaded, then waits.
module guided_depth_bilateral_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [19:0] cell_depth, [27:20] guide_red, [35:28] guide_green,
    // [43:36] guide_blue, [44] guide_valid, [47:45] zero
    input  logic [gdbf_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] drain
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [19:0] filtered_depth, [25:20] out_row, [35:26] out_column, [39:36] zero
    output logic [gdbf_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] passed_through
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [gdbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gdbf_pkg::CFG_DATA_W-1:0] cfg_data
);

    import gdbf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    gdbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gdbf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### sim/gdbf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for guided_depth_bilateral_filter: watches the input, output and config
// ports, predicts each result cell and compares it field by field. Needs gdbf_pkg.
module gdbf_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [gdbf_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [gdbf_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [gdbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gdbf_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              pending,
    output int                              errors
);

    import gdbf_pkg::*;

    typedef struct {
        logic [DEPTH_W-1:0]   depth;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 passed;
        logic                 last;
    } cell_out_t;

    localparam longint EXP_WHOLE [0:11] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                            22, 8, 3, 1};
    localparam longint EXP_PART [0:31] = '{
        65536, 63520, 61565, 59671, 57835, 56056, 54331, 52660,
        51039, 49469, 47947, 46472, 45042, 43657, 42314, 41012,
        39750, 38527, 37341, 36192, 35079, 34000, 32954, 31940,
        30957, 30005, 29081, 28187, 27319, 26479, 25664, 24875};

    logic [CELL_W-1:0] line_mem [0:STORE_CELLS-1];
    cell_out_t         result_q [$];
    int                in_row, in_col, out_idx;
    logic [WS_W-1:0]   win_reg;
    logic [INV_W-1:0]  sp_reg, rg_reg;

    function automatic longint int_sqrt(input longint v);
        longint res = 0;
        longint probe = 64'd1 << 30;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end
            else res = res >> 1;
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic longint depth_of(input logic [CELL_W-1:0] c);
        return longint'($signed(c[19:0]));
    endfunction

    function automatic longint pair_weight(input int dx, input int dy,
                                           input logic [CELL_W-1:0] a,
                                           input logic [CELL_W-1:0] b);
        longint dr, dg, db, d4, x;
        dr = longint'(a[27:20]) - longint'(b[27:20]);
        dg = longint'(a[35:28]) - longint'(b[35:28]);
        db = longint'(a[43:36]) - longint'(b[43:36]);
        d4 = int_sqrt((dr * dr + dg * dg + db * db) * 256);
        x  = longint'((dx * dx + dy * dy) >> 1) * sp_reg + ((d4 * rg_reg) >> 8);
        if ((x >> 12) >= 12) return 0;
        return (EXP_WHOLE[x >> 12] * EXP_PART[(x >> 7) & 31] + 32768) >> 16;
    endfunction

    function automatic cell_out_t filter_cell(input int k);
        cell_out_t         o;
        int                i, j, r, lo, hi, y, xc;
        logic [CELL_W-1:0] c0, c1;
        longint            num, den, w, q;
        i = k / GRID_WIDTH;
        j = k % GRID_WIDTH;
        c0 = line_mem[(i % MAX_WINDOW) * GRID_WIDTH + j];
        q = depth_of(c0);
        o.passed = 1'b1;
        if (c0[44]) begin
            r = win_reg;
            if (r < 1) r = 1;
            if (r > MAX_WINDOW) r = MAX_WINDOW;
            lo = -(r / 2);
            hi = r - 1 - r / 2;
            num = 0;
            den = 0;
            for (int dy = lo; dy <= hi; dy++) begin
                y = i + dy;
                if (y < 0 || y >= GRID_ROWS) continue;
                for (int dx = lo; dx <= hi; dx++) begin
                    xc = j + dx;
                    if (xc < 0 || xc >= GRID_WIDTH) continue;
                    c1 = line_mem[(y % MAX_WINDOW) * GRID_WIDTH + xc];
                    if (!c1[44]) continue;
                    w = pair_weight(dx, dy, c0, c1);
                    num += w * depth_of(c1);
                    den += w;
                end
            end
            if (den > 0) begin
                // round half away from zero, then saturate
                q = (num >= 0) ? (num + den / 2) / den : -((-num + den / 2) / den);
                if (q > DEPTH_POS_MAX) q = DEPTH_POS_MAX;
                if (q < -DEPTH_NEG_MAG) q = -DEPTH_NEG_MAG;
            end
            o.passed = 1'b0;
        end
        o.depth = q[DEPTH_W-1:0];
        o.row   = i[OUT_ROW_W-1:0];
        o.col   = j[OUT_COL_W-1:0];
        o.last  = (k == TOTAL - 1);
        return o;
    endfunction

    task automatic take_word(input logic drain, input logic [S_TDATA_W-1:0] w);
        if (in_row < GRID_ROWS && drain) return;
        if (in_row < GRID_ROWS) line_mem[(in_row % MAX_WINDOW) * GRID_WIDTH + in_col] = w[44:0];
        in_col++;
        if (in_col >= GRID_WIDTH) begin
            in_col = 0;
            in_row++;
        end
        if (out_idx < TOTAL && in_row * GRID_WIDTH + in_col > out_idx + DELAY) begin
            result_q.push_back(filter_cell(out_idx));
            out_idx++;
            if (out_idx >= TOTAL) begin
                out_idx = 0;
                in_row = 0;
                in_col = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        cell_out_t e;
        if (!rst_n) begin
            result_q.delete();
            in_row  = 0;
            in_col  = 0;
            out_idx = 0;
            win_reg = WS_W'(WS_RESET);
            sp_reg  = INV_W'(SP_RESET);
            rg_reg  = INV_W'(RG_RESET);
            errors  = 0;
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WINDOW_SIZE: win_reg = cfg_data[WS_W-1:0];
                    CFG_SPATIAL_INV: sp_reg  = cfg_data;
                    CFG_RANGE_INV:   rg_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result word with none expected: %h", $realtime, m_tdata);
                end
                else begin
                    e = result_q.pop_front();
                    if (m_tdata[19:0] !== e.depth || m_tdata[25:20] !== e.row
                        || m_tdata[35:26] !== e.col || m_tuser !== e.passed
                        || m_tlast !== e.last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: cell r%0d c%0d exp depth %h pass %b last %b,",
                                      " got r%0d c%0d depth %h pass %b last %b"},
                                     $realtime, e.row, e.col, e.depth, e.passed, e.last,
                                     m_tdata[25:20], m_tdata[35:26], m_tdata[19:0],
                                     m_tuser, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) take_word(s_tuser, s_tdata);
        end
        pending = result_q.size();
    end

endmodule

### sim/tb_guided_depth_bilateral_filter.sv
`timescale 1ns / 1ps
// Top of the guided depth bilateral filter bench: clock, reset, stimulus and verdict.
// Depends on gdbf_pkg, guided_depth_bilateral_filter and gdbf_checker.
module tb_guided_depth_bilateral_filter;
    import gdbf_pkg::*;

    localparam int CYCLE_LIMIT = 60_000_000;
    localparam int SETTLE      = 400;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_WINDOW_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int         pending, errors;
    int         cycles = 0;
    bit         src_gaps_on = 1'b1;
    bit         sink_gaps_on = 1'b1;
    bit         hold_req = 1'b0;
    logic [7:0] base_r, base_g, base_b;

    always #4 clk = ~clk;

    guided_depth_bilateral_filter u_dut (.*);

    gdbf_checker u_chk (.*);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random backpressure, plus one long hold-off on request
    initial begin
        repeat (6) @(posedge clk);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            else m_tready <= !(sink_gaps_on && $urandom_range(99) < 12);
        end
    end

    task automatic push_word(input logic drain, input logic [19:0] d, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b, input logic v);
        if (src_gaps_on && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, v, b, g, r, d};
        s_tuser  <= drain;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic push_rand(input logic drain);
        push_word(drain, 20'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom));
    endtask

    task automatic push_cell(input int row, input int col);
        logic [19:0] d;
        logic [7:0]  r, g, b;
        logic        v;
        if (col == 0) {base_r, base_g, base_b} = 24'($urandom);
        d = 20'($urandom);
        // dense guides near the left edge, sparse elsewhere to keep the run short
        v = (col < 24) ? ($urandom_range(3) != 0) : ($urandom_range(127) == 0);
        if ($urandom_range(1) != 0) begin
            r = base_r + 8'($urandom_range(7));
            g = base_g + 8'($urandom_range(7));
            b = base_b + 8'($urandom_range(7));
        end
        else {r, g, b} = 24'($urandom);
        if (row == 0 && col < 25) begin
            case (col % 5)
                0:       d = 20'h7FFFF;
                1:       d = 20'h80000;
                2:       d = 20'h00000;
                3:       d = 20'hFFFFF;
                default: d = 20'($urandom);
            endcase
            v = (col != 7 && col != 13);
            r = (col % 2) ? 8'hFF : 8'h00;
            g = (col % 3 == 0) ? 8'hFF : 8'h00;
            b = (col % 4 == 0) ? 8'h00 : 8'hFF;
        end
        // drain tick inside the frame: dropped by the block
        if ($urandom_range(63) == 0) push_rand(1'b1);
        push_word(1'b0, d, r, g, b, v);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_filter(input int ws, input int sp, input int rg);
        cfg_write(CFG_WINDOW_SIZE, CFG_DATA_W'(ws));
        cfg_write(CFG_SPATIAL_INV, CFG_DATA_W'(sp));
        cfg_write(CFG_RANGE_INV, CFG_DATA_W'(rg));
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int row = 0; row < GRID_ROWS; row++) begin
            if (row % 8 == 0 && row != 0) begin
                settle();
                case (row / 8)
                    1: set_filter(9, 0, 0);
                    2: set_filter(1, 65535, 65535);
                    3: set_filter(0, 20000, 500);
                    4: set_filter(15, 4096, 300);
                    5: set_filter(3, $urandom_range(65535), $urandom_range(65535));
                    6: set_filter(8, 12000, 40);
                    default: set_filter($urandom_range(15), $urandom_range(65535),
                                        $urandom_range(2000));
                endcase
            end
            if (row == 4) hold_req = 1'b1;
            if (row == 16) src_gaps_on = 1'b0;
            if (row == 24) src_gaps_on = 1'b1;
            if (row == 32) sink_gaps_on = 1'b0;
            if (row == 40) sink_gaps_on = 1'b1;
            for (int col = 0; col < GRID_WIDTH; col++) push_cell(row, col);
        end
        // tail of the frame: drain ticks, with stray data words that act as drains
        for (int n = 0; n < DELAY; n++) begin
            if ($urandom_range(9) == 0)
                push_rand(1'b0);
            else
                push_rand(1'b1);
        end
        settle();
        set_filter($urandom_range(1, 9), $urandom_range(65535), $urandom_range(1000));
        // start of a second frame
        for (int k = 0; k < DELAY + 60; k++) push_cell(k / GRID_WIDTH, k % GRID_WIDTH);
        settle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
src/gdbf_pkg.sv
src/gdbf_ram.sv
src/gdbf_div.sv
src/gdbf_ctrl.sv
src/gdbf_dp.sv
src/guided_depth_bilateral_filter.sv
sim/gdbf_checker.sv
sim/tb_guided_depth_bilateral_filter.sv
